@@ rtl/assert_macros.svh @@
// assertion macros shared by the cache modules
// no dependencies; included by the files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define ACACHE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define ACACHE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/acache_pkg.sv @@
// types, codes and default sizes for the associative cache
// no dependencies; imported by every cache module
package acache_pkg;

  localparam int WAYS_DEF       = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int INDEX_W = 4;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_FILL   = 1'b1
  } kind_e;

  typedef enum logic {
    POLICY_LRU = 1'b0,
    POLICY_LFU = 1'b1
  } policy_e;

  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0] fill_value;
  } acache_in_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] entry_index;
    logic [VALUE_W-1:0] read_value;
    logic               error;
  } acache_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic touch;
    logic scan_step;
    logic write;
    logic respond;
  } acache_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_fill;
    logic found;
    logic free_found;
    logic scan_last;
    logic out_free;
  } acache_stat_t;

endpackage

@@ rtl/acache_ctrl.sv @@
// sequencer of the associative cache: match, touch, victim scan, write, respond
// depends on acache_pkg and assert_macros.svh
`include "assert_macros.svh"

module acache_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  acache_pkg::acache_stat_t  stat_i,
  output acache_pkg::acache_cmd_t   cmd_o
);
  import acache_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_TOUCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_ready;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    in_ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        if (!stat_i.is_fill) begin
          state_d = stat_i.found ? S_TOUCH : S_RESP;
        end else if (stat_i.found) begin
          state_d = S_RESP;
        end else if (stat_i.free_found) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_TOUCH: begin
        cmd_o.touch = 1'b1;
        state_d     = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        // next beat may enter as this result lands in the output register
        if (stat_i.out_free) begin
          cmd_o.respond = 1'b1;
          in_ready      = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.capture = in_valid_i && in_ready;
    if (cmd_o.capture) begin
      state_d = S_MATCH;
    end
  end

  assign in_ready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ACACHE_ASSERT(a_capture_to_match, clk_i, rst_ni, cmd_o.capture |=> state_q == S_MATCH, "capture did not start a match")
  `ACACHE_ASSERT(a_single_action, clk_i, rst_ni, $onehot0({cmd_o.match, cmd_o.touch, cmd_o.scan_step, cmd_o.write, cmd_o.respond}), "more than one datapath action")
  `ACACHE_ASSERT(a_scan_to_write, clk_i, rst_ni, (state_q == S_SCAN && stat_i.scan_last) |=> state_q == S_WRITE, "victim scan did not end in a write")

endmodule

@@ rtl/acache_dp.sv @@
// datapath of the associative cache: key cells, ages, counts, value memory
// depends on acache_pkg and assert_macros.svh
`include "assert_macros.svh"

module acache_dp #(
  parameter int WAYS       = acache_pkg::WAYS_DEF,
  parameter int KEY_BITS   = acache_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = acache_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = acache_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acache_pkg::policy_e       policy_i,
  input  acache_pkg::acache_in_t    in_data_i,
  input  acache_pkg::acache_cmd_t   cmd_i,
  output acache_pkg::acache_stat_t  stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output acache_pkg::acache_out_t   out_data_o
);
  import acache_pkg::*;

  localparam int IDX_BITS = $clog2(WAYS);
  localparam int AGE_BITS = IDX_BITS;
  localparam logic [AGE_BITS-1:0]   AGE_MAX  = AGE_BITS'(WAYS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [IDX_BITS-1:0]   IDX_LAST = IDX_BITS'(WAYS - 1);

  // current item
  kind_e                 kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // table
  logic [WAYS-1:0]       valid_q;
  logic [KEY_BITS-1:0]   key_store_q [WAYS];
  logic [AGE_BITS-1:0]   age_q [WAYS];
  logic [COUNT_BITS-1:0] cnt_q [WAYS];
  logic [VALUE_BITS-1:0] value_mem [WAYS];
  logic [VALUE_BITS-1:0] rdata_q;

  logic [IDX_BITS-1:0]   sel_idx_q;
  logic                  hit_q;
  logic                  err_q;
  logic [IDX_BITS-1:0]   scan_idx_q;
  logic [IDX_BITS-1:0]   best_idx_q;
  logic [AGE_BITS-1:0]   best_age_q;
  logic [COUNT_BITS-1:0] best_cnt_q;

  logic                  out_valid_q;
  acache_out_t           out_q;

  logic                  found;
  logic [IDX_BITS-1:0]   match_idx;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;
  logic [IDX_BITS-1:0]   rd_idx;
  logic [AGE_BITS-1:0]   age_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  take;

  // parallel key compare, lowest matching and lowest free entry win
  always_comb begin
    found      = 1'b0;
    match_idx  = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_store_q[i] == key_q) begin
        found     = 1'b1;
        match_idx = IDX_BITS'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  // one read port on ages and counts, shared by touch and victim scan
  assign rd_idx = cmd_i.scan_step ? scan_idx_q : sel_idx_q;
  assign age_rd = age_q[rd_idx];
  assign cnt_rd = cnt_q[rd_idx];

  // lru keeps the first oldest entry, lfu the last least used one
  assign take = (scan_idx_q == '0) ||
                ((policy_i == POLICY_LFU) ? (cnt_rd <= best_cnt_q) : (age_rd > best_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '{default: '0};
      cnt_q   <= '{default: '0};
    end else begin
      if (cmd_i.touch) begin
        if (policy_i == POLICY_LRU) begin
          for (int i = 0; i < WAYS; i++) begin
            if (IDX_BITS'(i) == sel_idx_q) begin
              age_q[i] <= '0;
            end else if (valid_q[i] && age_q[i] < age_rd) begin
              age_q[i] <= age_q[i] + AGE_BITS'(1);
            end
          end
        end else if (cnt_rd != CNT_MAX) begin
          cnt_q[sel_idx_q] <= cnt_rd + COUNT_BITS'(1);
        end
      end
      if (cmd_i.write) begin
        valid_q[sel_idx_q] <= 1'b1;
        if (policy_i == POLICY_LRU) begin
          // new entry enters as the oldest and is then touched
          for (int i = 0; i < WAYS; i++) begin
            if (IDX_BITS'(i) == sel_idx_q) begin
              age_q[i] <= '0;
            end else if (valid_q[i] && age_q[i] < AGE_MAX) begin
              age_q[i] <= age_q[i] + AGE_BITS'(1);
            end
          end
        end else begin
          cnt_q[sel_idx_q] <= COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.match) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + IDX_BITS'(1);
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_data_i.kind;
      key_q  <= in_data_i.lookup_key[KEY_BITS-1:0];
      val_q  <= in_data_i.fill_value[VALUE_BITS-1:0];
    end
    if (cmd_i.match) begin
      hit_q <= found;
      err_q <= found && (kind_q == KIND_FILL);
      if (found) begin
        sel_idx_q <= match_idx;
      end else if (kind_q == KIND_FILL) begin
        sel_idx_q <= free_idx;
      end else begin
        sel_idx_q <= '0;
      end
    end
    if (cmd_i.scan_step) begin
      if (take) begin
        best_idx_q <= scan_idx_q;
        best_age_q <= age_rd;
        best_cnt_q <= cnt_rd;
      end
      if (scan_idx_q == IDX_LAST) begin
        sel_idx_q <= take ? scan_idx_q : best_idx_q;
      end
    end
    if (cmd_i.write) begin
      key_store_q[sel_idx_q] <= key_q;
    end
    if (cmd_i.respond) begin
      out_q.hit         <= hit_q;
      out_q.entry_index <= INDEX_W'(sel_idx_q);
      out_q.read_value  <= (kind_q == KIND_LOOKUP && hit_q) ? VALUE_W'(rdata_q) : '0;
      out_q.error       <= err_q;
    end
  end

  // value memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      value_mem[sel_idx_q] <= val_q;
    end
    if (cmd_i.touch) begin
      rdata_q <= value_mem[sel_idx_q];
    end
  end

  assign stat_o.is_fill    = (kind_q == KIND_FILL);
  assign stat_o.found      = found;
  assign stat_o.free_found = free_found;
  assign stat_o.scan_last  = (scan_idx_q == IDX_LAST);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ACACHE_ASSERT(a_write_sets_valid, clk_i, rst_ni, cmd_i.write |=> valid_q[$past(sel_idx_q)], "written entry not valid")
  `ACACHE_ASSERT(a_respond_when_free, clk_i, rst_ni, cmd_i.respond |-> (!out_valid_q || out_ready_i), "result overwrote a waiting beat")
  `ACACHE_ASSERT_ALWAYS(a_error_is_hit, clk_i, out_valid_q |-> (!out_q.error || out_q.hit), "error flagged without a hit")

endmodule

@@ rtl/assoc_cache_lru_lfu.sv @@
// Fully associative key-value cache, WAYS entries, LRU or LFU replacement.
// Input channel in_valid_i/in_ready_o carries one beat per operation: a lookup
// of a key, or a fill of a key with a value. Output channel
// out_valid_o/out_ready_i returns exactly one beat per operation: hit flag,
// entry index, value read on a lookup hit, and an error flag for a fill of a
// key that is already present (the table is then left as it was).
// Config channel cfg_valid_i/cfg_ready_o writes the policy bit (0 LRU, 1 LFU);
// it is always ready; the user must see that it is written only while the
// cache is idle, as the block itself does not enforce it.
// A lookup miss or a duplicate fill passes match and respond; a lookup hit
// adds a touch, a fill into a free entry a write, and a fill into a full
// table a victim scan and a write, where the victim is found by a scan of
// the ages or counts at one entry per cycle through a single read port.
// The next beat is taken in the cycle the result is registered.
// A stalled receiver holds the result in the output register; one more beat
// can be taken and worked on, then the cache waits.
// Reset clears all entries, ages and counts and selects LRU.
// depends on acache_pkg, acache_ctrl and acache_dp
module assoc_cache_lru_lfu #(
  parameter int WAYS       = acache_pkg::WAYS_DEF,
  parameter int KEY_BITS   = acache_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = acache_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = acache_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  acache_pkg::acache_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output acache_pkg::acache_out_t  out_data_o
);
  import acache_pkg::*;

  policy_e      policy_q;
  acache_cmd_t  cmd;
  acache_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_LRU;
    end else if (cfg_valid_i && cfg_ready_o) begin
      policy_q <= policy_e'(cfg_data_i);
    end
  end

  acache_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acache_dp #(
    .WAYS       (WAYS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_i    (policy_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
